[hw/rtl/rvdiv_pkg.sv]
// ----------------------------------------------------------------------------
// rvdiv_pkg: shared types and constants for the integer divider
// Holds the register width, request code bits and the word passed
// between the cells of the divider chain.
// ----------------------------------------------------------------------------
package rvdiv_pkg;

  localparam int XLEN = 64;
  localparam int NCELL = XLEN;

  localparam int RQ_UNSIGNED  = 0;
  localparam int RQ_REMAINDER = 1;
  localparam int RQ_WORD      = 2;

  // Sideband that travels with a word through the chain.
  typedef struct packed {
    logic            vld;
    logic            div_zero;
    logic            ovf;
    logic            word;
    logic            want_rem;
    logic            neg_q;
    logic            neg_r;
    logic [XLEN-1:0] a_orig;
  } rvdiv_ctl_t;

  // State of one division in flight.
  typedef struct packed {
    rvdiv_ctl_t      ctl;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] dvs;
  } rvdiv_word_t;

endpackage

[hw/rtl/rvdiv_cell.sv]
// ----------------------------------------------------------------------------
// rvdiv_cell: one restoring division step
// Shifts in one dividend bit, trial-subtracts the divisor and registers
// the result for the next cell. The cell advances only when enabled.
// ----------------------------------------------------------------------------
module rvdiv_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  rvdiv_pkg::rvdiv_word_t din,
  output rvdiv_pkg::rvdiv_word_t dout
);
  import rvdiv_pkg::*;

  logic [XLEN:0]   part;
  logic [XLEN:0]   diff;
  rvdiv_word_t     dout_next;

  always_comb begin
    part = {din.rem, din.quo[XLEN-1]};
    diff = part - {1'b0, din.dvs};
    dout_next = din;
    dout_next.quo = {din.quo[XLEN-2:0], ~diff[XLEN]};
    dout_next.rem = diff[XLEN] ? part[XLEN-1:0] : diff[XLEN-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.ctl.vld <= 1'b0;
    end else if (en) begin
      dout.ctl.vld <= din.ctl.vld;
    end
    if (en) begin
      dout.ctl.div_zero <= dout_next.ctl.div_zero;
      dout.ctl.ovf      <= dout_next.ctl.ovf;
      dout.ctl.word     <= dout_next.ctl.word;
      dout.ctl.want_rem <= dout_next.ctl.want_rem;
      dout.ctl.neg_q    <= dout_next.ctl.neg_q;
      dout.ctl.neg_r    <= dout_next.ctl.neg_r;
      dout.ctl.a_orig   <= dout_next.ctl.a_orig;
      dout.rem          <= dout_next.rem;
      dout.quo          <= dout_next.quo;
      dout.dvs          <= dout_next.dvs;
    end
  end

endmodule

[hw/rtl/riscv_integer_divider_core.sv]
// ----------------------------------------------------------------------------
// riscv_integer_divider_core: pipelined RISC-V M-extension divider
// Computes DIV, DIVU, REM, REMU and their word forms in a chain of
// restoring division cells, one quotient bit per cell.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid/in_stall) carries req_type, dividend and
//   divisor; the result channel (out_valid/out_stall) carries one 64-bit
//   quotient_or_remainder word per request, in request order.
//   One input register, 64 division cells and one output register form the
//   pipeline. A new word is accepted every cycle unless the output register
//   is stalled; throughput is one word per cycle, set by the chain of cells.
//   The whole pipeline advances as one: when out_stall holds a finished
//   word in the output register, every stage holds and in_stall rises for
//   as long as that word waits, whether or not the input register is
//   occupied. Empty stages are not squeezed out.
//   Reset clears all valid bits; payload registers are not cleared.
// ----------------------------------------------------------------------------
module riscv_integer_divider_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 req_type,
  input  logic [63:0]                dividend,
  input  logic [63:0]                divisor,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [63:0]                quotient_or_remainder
);
  import rvdiv_pkg::*;

  logic            adv;
  rvdiv_word_t     head;
  rvdiv_word_t     chain [NCELL+1];
  logic [XLEN-1:0] res_next;
  logic [XLEN-1:0] m;
  logic [XLEN-1:0] top;
  logic [XLEN-1:0] a;
  logic [XLEN-1:0] b;
  logic            na;
  logic            nb;
  logic            sgn;
  rvdiv_word_t     head_next;
  logic            res_vld;
  logic [XLEN-1:0] res;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Operand preparation: mask to width, take magnitudes, flag special cases.
  always_comb begin
    m   = req_type[RQ_WORD] ? XLEN'(64'hFFFF_FFFF) : '1;
    top = req_type[RQ_WORD] ? XLEN'(64'h8000_0000) : {1'b1, {(XLEN-1){1'b0}}};
    a   = dividend[XLEN-1:0] & m;
    b   = divisor[XLEN-1:0] & m;
    sgn = !req_type[RQ_UNSIGNED];
    na  = sgn && ((a & top) != '0);
    nb  = sgn && ((b & top) != '0);
    head_next = '0;
    head_next.ctl.vld      = in_valid;
    head_next.ctl.word     = req_type[RQ_WORD];
    head_next.ctl.want_rem = req_type[RQ_REMAINDER];
    head_next.ctl.div_zero = (b == '0);
    head_next.ctl.ovf      = sgn && (a == top) && (b == m);
    head_next.ctl.neg_q    = na ^ nb;
    head_next.ctl.neg_r    = na;
    head_next.ctl.a_orig   = a;
    head_next.quo = na ? ((~a + XLEN'(1)) & m) : a;
    head_next.dvs = nb ? ((~b + XLEN'(1)) & m) : b;
    head_next.rem = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.ctl.vld <= 1'b0;
    end else if (adv) begin
      head.ctl.vld <= in_valid;
    end
    if (adv) begin
      head.ctl.div_zero <= head_next.ctl.div_zero;
      head.ctl.ovf      <= head_next.ctl.ovf;
      head.ctl.word     <= head_next.ctl.word;
      head.ctl.want_rem <= head_next.ctl.want_rem;
      head.ctl.neg_q    <= head_next.ctl.neg_q;
      head.ctl.neg_r    <= head_next.ctl.neg_r;
      head.ctl.a_orig   <= head_next.ctl.a_orig;
      head.quo          <= head_next.quo;
      head.dvs          <= head_next.dvs;
      head.rem          <= head_next.rem;
    end
  end

  assign chain[0] = head;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rvdiv_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Sign restore, special cases and sign extension of word results.
  always_comb begin
    rvdiv_word_t t;
    logic [XLEN-1:0] q;
    logic [XLEN-1:0] r;
    logic [XLEN-1:0] v;
    t = chain[NCELL];
    q = t.ctl.neg_q ? (~t.quo + XLEN'(1)) : t.quo;
    r = t.ctl.neg_r ? (~t.rem + XLEN'(1)) : t.rem;
    if (t.ctl.div_zero) begin
      q = '1;
      r = t.ctl.a_orig;
    end else if (t.ctl.ovf) begin
      q = t.ctl.a_orig;
      r = '0;
    end
    v = t.ctl.want_rem ? r : q;
    if (t.ctl.word) begin
      v = {{(XLEN-32){v[31]}}, v[31:0]};
    end
    res_next = v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= chain[NCELL].ctl.vld;
    end
    if (adv) begin
      res <= res_next;
    end
  end

  assign out_valid = res_vld;
  assign quotient_or_remainder = 64'(res);

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(quotient_or_remainder))
    else $error("result word changed while stalled");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");
  a_first: assert property (@(posedge clk) disable iff (rst)
    !head.ctl.vld && adv |=> !chain[1].ctl.vld)
    else $error("bubble lost in divider chain");
`endif

endmodule

[verif/riscv_integer_divider_core_test.sv]
// ----------------------------------------------------------------------------
// riscv_integer_divider_core_test: self-checking bench for the divider
// Drives division requests with random idling on both channels, predicts
// each quotient or remainder word and checks the results in order.
// ----------------------------------------------------------------------------
module riscv_integer_divider_core_test;
  import rvdiv_pkg::*;

  class div_scoreboard;
    logic [63:0] pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function logic [63:0] divide(logic [2:0] rq, logic [63:0] a_raw, logic [63:0] b_raw);
      logic [63:0] m, top, a, b, q, r, ua, ub, uq, ur, res;
      logic na, nb, word;
      word = rq[RQ_WORD];
      m = word ? 64'h0000_0000_ffff_ffff : '1;
      top = word ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
      a = a_raw & m;
      b = b_raw & m;
      if (b == 0) begin
        q = m;
        r = a;
      end else if (rq[RQ_UNSIGNED]) begin
        q = a / b;
        r = a % b;
      end else if (a == top && b == m) begin
        q = top;
        r = 0;
      end else begin
        na = (a & top) != 0;
        nb = (b & top) != 0;
        ua = na ? ((64'd0 - a) & m) : a;
        ub = nb ? ((64'd0 - b) & m) : b;
        uq = ua / ub;
        ur = ua % ub;
        q = (na != nb) ? ((64'd0 - uq) & m) : uq;
        r = na ? ((64'd0 - ur) & m) : ur;
      end
      res = rq[RQ_REMAINDER] ? r : q;
      if (word && res[31]) res = res | ~m;
      return res;
    endfunction

    function void note_request(logic [2:0] rq, logic [63:0] a, logic [63:0] b);
      pending.push_back(divide(rq, a, b));
    endfunction

    function void check_result(logic [63:0] got);
      logic [63:0] exp_word;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      exp_word = pending.pop_front();
      if (got !== exp_word) begin
        $display("%0t: quotient_or_remainder expected %h actual %h", $time, exp_word, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  logic [2:0] req_type;
  logic [63:0] dividend, divisor, quotient_or_remainder;
  div_scoreboard results;
  int idle_cycles;
  bit calm;

  riscv_integer_divider_core i_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Receiver side: random stall bursts, none once the run is calm.
  initial begin
    int n;
    out_stall = 1;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst) idle_cycles <= 0;
    else if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && out_valid && !out_stall) results.check_result(quotient_or_remainder);
    if (!rst && in_valid && !in_stall) results.note_request(req_type, dividend, divisor);
    if (idle_cycles > 2000) begin
      $display("riscv_integer_divider_core_test NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'd0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000;
      3: v = {$urandom, 32'h8000_0000};
      4: v = {$urandom, 32'hffff_ffff};
      5: v = {$urandom, 32'h0};
      6: v = 64'($urandom_range(0, 20));
      7: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic send(logic [2:0] rq, logic [63:0] a, logic [63:0] b);
    int n;
    if (!calm && $urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 18);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= rq;
    dividend <= a;
    divisor <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [63:0] ops[6];
    results = new();
    rst = 1;
    in_valid = 0;
    req_type = 0;
    dividend = 0;
    divisor = 0;
    calm = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    ops = '{64'd0, '1, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
            64'hffff_ffff_8000_0000, 64'h0000_0000_ffff_ffff};
    // Zero divisor, overflow, minus 2^31 as divisor with all codes, minus 2^63 with DIV.
    for (int t = 0; t < 8; t++) begin
      send(t[2:0], ops[$urandom_range(1, 5)], 64'd0);
      send(t[2:0], ops[2], '1);
      send(t[2:0], 64'h1234_5678_8000_0000, 64'h0000_0000_ffff_ffff);
      send(t[2:0], ops[1], ops[4]);
    end
    send(3'd0, 64'd100, ops[2]);
    // Let the pipeline drain fully before going on.
    in_valid <= 0;
    @(posedge clk);
    while (results.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < 750; i++) begin
      if (i == 650) calm = 1;
      send(3'($urandom_range(0, 7)), pick_operand(), pick_operand());
    end
    in_valid <= 0;
    while (results.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (results.errors == 0) $display("riscv_integer_divider_core_test OK");
    else $display("riscv_integer_divider_core_test NOT OK");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/rvdiv_pkg.sv
hw/rtl/rvdiv_cell.sv
hw/rtl/riscv_integer_divider_core.sv
verif/riscv_integer_divider_core_test.sv
